>>> hw/rtl/segment_segment_distance_unit_defines.svh
// assertion macros for the segment distance unit
// expects clk_i and rst_ni in the scope of every use
`ifndef SEGMENT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH
`define SEGMENT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH

// same-cycle implication
`define SSD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("ssd: same-cycle check failed");

// next-cycle implication
`define SSD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ssd: next-cycle check failed");

`endif

>>> hw/rtl/ssd_pkg.sv
// types and fixed widths shared by the segment distance unit
// no dependencies
package ssd_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int DistBits  = 25;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
    coord_t d_x;
    coord_t d_y;
  } in_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic                touching;
  } out_t;

endpackage

>>> hw/rtl/segment_segment_distance_unit.sv
// segment-to-segment distance unit, fully pipelined top level
// depends on ssd_pkg and segment_segment_distance_unit_defines.svh
//
// One transaction enters per cycle whenever start is high; busy never rises. Each result
// appears on result_o for one cycle with valid_o. The pipeline depth is set by the
// bit-per-stage restoring divider (one quotient bit per stage, four lanes, one per
// endpoint-to-segment candidate) and the bit-per-stage square root that follows the
// minimum of the four quotients, with QW = 2*CoordBits+1+2*FracBits quotient bits and
// RW = ceil(QW/2) root bits. Results come in start order, unthrottled.
`include "segment_segment_distance_unit_defines.svh"

module segment_segment_distance_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ssd_pkg::in_t  item_i,
  output logic          valid_o,
  output ssd_pkg::out_t result_o
);

  localparam int DW   = ssd_pkg::CoordBits + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int MagW = 2 * ssd_pkg::CoordBits + 2;
  localparam int NumW = 2 * MagW;
  localparam int QW   = 2 * ssd_pkg::CoordBits + 1 + 2 * ssd_pkg::FracBits;
  localparam int DivW = NumW + 2 * ssd_pkg::FracBits;
  localparam int RW   = (QW + 1) / 2;
  localparam int SqW  = 2 * RW;
  localparam int Lat  = 9 + QW + RW;

  typedef struct packed {
    ssd_pkg::coord_t x;
    ssd_pkg::coord_t y;
  } pt_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } vec_t;

  function automatic logic lex_less(pt_t u, pt_t v);
    lex_less = (u.x != v.x) ? ($signed(u.x) < $signed(v.x)) : ($signed(u.y) < $signed(v.y));
  endfunction

  function automatic pt_t lex_min(pt_t u, pt_t v);
    lex_min = lex_less(v, u) ? v : u;
  endfunction

  function automatic pt_t lex_max(pt_t u, pt_t v);
    lex_max = lex_less(u, v) ? v : u;
  endfunction

  function automatic vec_t vsub(pt_t p, pt_t q);
    vec_t r;
    r.x = DW'(p.x) - DW'(q.x);
    r.y = DW'(p.y) - DW'(q.y);
    vsub = r;
  endfunction

  logic [Lat-1:0] vld_q;

  // stage 1: endpoints
  pt_t pt_q [4];

  // stage 2: differences
  vec_t e_q [4];
  vec_t w0_q [4];
  vec_t w1_q [4];
  logic s2_same_ab_q, s2_same_cd_q, s2_ov_q;

  // stage 3: products
  logic signed [PW-1:0] pex_q [4], pey_q [4], pdx_q [4], pdy_q [4], pcx_q [4], pcy_q [4];
  logic signed [PW-1:0] pax_q [4], pay_q [4], pbx_q [4], pby_q [4];
  logic signed [PW-1:0] g_q [6];
  logic s3_same_ab_q, s3_same_cd_q, s3_ov_q;

  // stage 4: sums
  logic [MagW-1:0]      n_q [4], d0_q [4], d1_q [4];
  logic signed [SW-1:0] dd_q [4], cr_q [4];
  logic signed [SW-1:0] c1_q, c2_q, tn_q;
  logic s4_same_ab_q, s4_same_cd_q, s4_ov_q;

  // stage 5: case selection
  logic            ispt_q [4], zero_q [4];
  logic [MagW-1:0] ptsq_q [4], mag_q [4], den5_q [4];
  logic [3:0]      act5_q;
  logic            tg5_q, deg5_q;

  // divider stages, index 0 is loaded from stage 5
  logic [MagW-1:0] rem_q [QW+1][4];
  logic [QW-1:0]   low_q [QW+1][4];
  logic [MagW-1:0] den_q [QW+1][4];
  logic [3:0]      dact_q [QW+1];
  logic            dtch_q [QW+1];
  logic            deg6_q;

  // minimum tree
  logic [QW-1:0] m1_q [2];
  logic          m1_tch_q;

  // square root stages
  logic [SqW-1:0]  x_q [RW+1];
  logic [RW-1:0]   rt_q [RW+1];
  logic [RW+1:0]   sr_q [RW+1];
  logic            st_q [RW+1];

  ssd_pkg::out_t res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q[0].x <= item_i.a_x;
    pt_q[0].y <= item_i.a_y;
    pt_q[1].x <= item_i.b_x;
    pt_q[1].y <= item_i.b_y;
    pt_q[2].x <= item_i.c_x;
    pt_q[2].y <= item_i.c_y;
    pt_q[3].x <= item_i.d_x;
    pt_q[3].y <= item_i.d_y;
  end

  // shared flags through stages 2 to 4
  always_ff @(posedge clk_i) begin
    s2_same_ab_q <= (pt_q[0] == pt_q[1]);
    s2_same_cd_q <= (pt_q[2] == pt_q[3]);
    s2_ov_q      <= !lex_less(lex_min(lex_max(pt_q[0], pt_q[1]), lex_max(pt_q[2], pt_q[3])),
                              lex_max(lex_min(pt_q[0], pt_q[1]), lex_min(pt_q[2], pt_q[3])));
    s3_same_ab_q <= s2_same_ab_q;
    s3_same_cd_q <= s2_same_cd_q;
    s3_ov_q      <= s2_ov_q;
    s4_same_ab_q <= s3_same_ab_q;
    s4_same_cd_q <= s3_same_cd_q;
    s4_ov_q      <= s3_ov_q;
  end

  // crossing products: ab = e[2], cd = e[0], ac = w0[2]
  always_ff @(posedge clk_i) begin
    g_q[0] <= e_q[2].x * e_q[0].y;
    g_q[1] <= e_q[2].y * e_q[0].x;
    g_q[2] <= w0_q[2].x * e_q[2].y;
    g_q[3] <= w0_q[2].y * e_q[2].x;
    g_q[4] <= w0_q[2].x * e_q[0].y;
    g_q[5] <= w0_q[2].y * e_q[0].x;
    c1_q   <= SW'(g_q[0]) - SW'(g_q[1]);
    c2_q   <= SW'(g_q[2]) - SW'(g_q[3]);
    tn_q   <= SW'(g_q[4]) - SW'(g_q[5]);
  end

  logic colin, tin, uin, tg_d;
  logic [3:0] act_d;

  always_comb begin
    colin = (c1_q == '0) && (c2_q == '0);
    if (!c1_q[SW-1]) begin
      tin = !tn_q[SW-1] && (tn_q <= c1_q);
      uin = !c2_q[SW-1] && (c2_q <= c1_q);
    end else begin
      tin = (tn_q[SW-1] || tn_q == '0) && (tn_q >= c1_q);
      uin = (c2_q[SW-1] || c2_q == '0) && (c2_q >= c1_q);
    end
    tg_d = !s4_same_ab_q && !s4_same_cd_q &&
           (colin ? s4_ov_q : ((c1_q != '0) && tin && uin));
    if (s4_same_ab_q) begin
      act_d = 4'b0001;
    end else if (s4_same_cd_q) begin
      act_d = 4'b0100;
    end else if (tg_d) begin
      act_d = 4'b0000;
    end else begin
      act_d = 4'b1111;
    end
  end

  always_ff @(posedge clk_i) begin
    act5_q   <= act_d;
    tg5_q    <= tg_d;
    deg5_q   <= s4_same_ab_q | s4_same_cd_q;
    dact_q[0] <= act5_q;
    dtch_q[0] <= tg5_q | (|(act5_q & {zero_q[3], zero_q[2], zero_q[1], zero_q[0]}));
    deg6_q   <= deg5_q;
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int P  = l;
    localparam int S0 = (l < 2) ? 2 : 0;
    localparam int S1 = S0 + 1;

    logic            same, le0, ge_n;
    logic [NumW-1:0] num;
    logic [DivW-1:0] dvd;

    always_ff @(posedge clk_i) begin
      e_q[l]  <= vsub(pt_q[S1], pt_q[S0]);
      w0_q[l] <= vsub(pt_q[P], pt_q[S0]);
      w1_q[l] <= vsub(pt_q[P], pt_q[S1]);
      pex_q[l] <= e_q[l].x * e_q[l].x;
      pey_q[l] <= e_q[l].y * e_q[l].y;
      pdx_q[l] <= w0_q[l].x * e_q[l].x;
      pdy_q[l] <= w0_q[l].y * e_q[l].y;
      pcx_q[l] <= w0_q[l].x * e_q[l].y;
      pcy_q[l] <= w0_q[l].y * e_q[l].x;
      pax_q[l] <= w0_q[l].x * w0_q[l].x;
      pay_q[l] <= w0_q[l].y * w0_q[l].y;
      pbx_q[l] <= w1_q[l].x * w1_q[l].x;
      pby_q[l] <= w1_q[l].y * w1_q[l].y;
      n_q[l]  <= MagW'(pex_q[l]) + MagW'(pey_q[l]);
      d0_q[l] <= MagW'(pax_q[l]) + MagW'(pay_q[l]);
      d1_q[l] <= MagW'(pbx_q[l]) + MagW'(pby_q[l]);
      dd_q[l] <= SW'(pdx_q[l]) + SW'(pdy_q[l]);
      cr_q[l] <= SW'(pcx_q[l]) - SW'(pcy_q[l]);
    end

    always_comb begin
      same = (l < 2) ? s4_same_cd_q : s4_same_ab_q;
      le0  = dd_q[l][SW-1] || (dd_q[l] == '0);
      ge_n = !dd_q[l][SW-1] && (dd_q[l][SW-2:0] >= n_q[l]);
      num  = ispt_q[l] ? NumW'(ptsq_q[l]) : (NumW'(mag_q[l]) * NumW'(mag_q[l]));
      dvd  = DivW'(num) << (2 * ssd_pkg::FracBits);
    end

    always_ff @(posedge clk_i) begin
      ispt_q[l] <= same | le0 | ge_n;
      ptsq_q[l] <= (same | le0) ? d0_q[l] : d1_q[l];
      mag_q[l]  <= cr_q[l][SW-1] ? MagW'(-cr_q[l]) : MagW'(cr_q[l]);
      den5_q[l] <= n_q[l];
      zero_q[l] <= (same | le0 | ge_n) ? (((same | le0) ? d0_q[l] : d1_q[l]) == '0)
                                       : (cr_q[l] == '0);
      rem_q[0][l] <= dvd[QW +: MagW];
      low_q[0][l] <= dvd[QW-1:0];
      den_q[0][l] <= ispt_q[l] ? MagW'(1) : den5_q[l];
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
      logic [MagW:0] t;
      logic          ge;

      always_comb begin
        t  = {rem_q[k][l], low_q[k][l][QW-1]};
        ge = (t >= {1'b0, den_q[k][l]});
      end

      always_ff @(posedge clk_i) begin
        rem_q[k+1][l] <= ge ? MagW'(t - {1'b0, den_q[k][l]}) : t[MagW-1:0];
        low_q[k+1][l] <= {low_q[k][l][QW-2:0], ge};
        den_q[k+1][l] <= den_q[k][l];
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_divc
    always_ff @(posedge clk_i) begin
      dact_q[k+1] <= dact_q[k];
      dtch_q[k+1] <= dtch_q[k];
    end
  end

  logic [QW-1:0] qv [4];
  logic [QW-1:0] best;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qv[i] = dact_q[QW][i] ? low_q[QW][i] : '1;
    end
    best = (m1_q[0] < m1_q[1]) ? m1_q[0] : m1_q[1];
  end

  always_ff @(posedge clk_i) begin
    m1_q[0]  <= (qv[0] < qv[1]) ? qv[0] : qv[1];
    m1_q[1]  <= (qv[2] < qv[3]) ? qv[2] : qv[3];
    m1_tch_q <= dtch_q[QW];
    x_q[0]   <= m1_tch_q ? '0 : SqW'(best);
    rt_q[0]  <= '0;
    sr_q[0]  <= '0;
    st_q[0]  <= m1_tch_q;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+3:0] t, trial;
    logic          ge;

    always_comb begin
      t     = {sr_q[k], x_q[k][SqW-1 -: 2]};
      trial = (RW+4)'({rt_q[k], 2'b01});
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i) begin
      sr_q[k+1] <= ge ? (RW+2)'(t - trial) : t[RW+1:0];
      rt_q[k+1] <= {rt_q[k][RW-2:0], ge};
      x_q[k+1]  <= x_q[k] << 2;
      st_q[k+1] <= st_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.distance <= ssd_pkg::DistBits'(rt_q[RW]);
    res_q.touching <= st_q[RW];
  end

  assign valid_o  = vld_q[Lat-1];
  assign result_o = res_q;

  `SSD_ASSERT_IMP(a_touch_zero, valid_o && result_o.touching, result_o.distance == '0)
  `SSD_ASSERT_IMP(a_deg_one_lane, vld_q[5] && deg6_q, $onehot(dact_q[0]))
  `SSD_ASSERT_NXT(a_enter, start && !busy, vld_q[0])

endmodule

>>> test/segment_segment_distance_unit_tb.sv
// self-checking testbench for segment_segment_distance_unit
// drives a directed table, then random segment pairs, and checks every result in order
// depends on ssd_pkg and the segment_segment_distance_unit top level
module segment_segment_distance_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PeriodHalf  = 6;
  localparam int Latency     = 83;
  localparam int RandomItems = 2000;
  localparam int CycleLimit  = 400000;
  localparam logic [ssd_pkg::DistBits-1:0] DistMax = '1;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  typedef struct {
    logic [127:0]    num;
    longint unsigned den;
  } sq_dist_t;

  typedef struct {
    ssd_pkg::in_t  item;
    bit            known;
    ssd_pkg::out_t res;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  ssd_pkg::in_t  item_i = '0;
  logic          valid_o;
  ssd_pkg::out_t result_o;

  ssd_pkg::out_t expected_q[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    items_sent = 0;
  int    touches_seen = 0;
  longint cycles = 0;

  segment_segment_distance_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always begin
    #PeriodHalf clk_i = 1'b1;
    #PeriodHalf clk_i = 1'b0;
  end

  function automatic bit same_pt(point_t p, point_t q);
    return p.x == q.x && p.y == q.y;
  endfunction

  function automatic bit lex_lt(point_t u, point_t v);
    return u.x != v.x ? u.x < v.x : u.y < v.y;
  endfunction

  function automatic sq_dist_t pt_pt_sq(point_t p, point_t q);
    sq_dist_t s;
    longint dx, dy;
    dx = q.x - p.x;
    dy = q.y - p.y;
    s.num = 128'(dx * dx + dy * dy);
    s.den = 1;
    return s;
  endfunction

  function automatic sq_dist_t pt_seg_sq(point_t p, point_t a, point_t b);
    sq_dist_t s;
    longint abx, aby, apx, apy, n, d, cr;
    logic [127:0] mag;
    if (same_pt(a, b)) return pt_pt_sq(p, a);
    abx = b.x - a.x; aby = b.y - a.y;
    apx = p.x - a.x; apy = p.y - a.y;
    n = abx * abx + aby * aby;
    d = apx * abx + apy * aby;
    if (d <= 0) return pt_pt_sq(p, a);
    if (d >= n) return pt_pt_sq(p, b);
    cr = apx * aby - apy * abx;
    mag = 128'(cr < 0 ? -cr : cr);
    s.num = mag * mag;
    s.den = n;
    return s;
  endfunction

  function automatic logic [ssd_pkg::DistBits-1:0] fixed_root(sq_dist_t s);
    logic [127:0] lo, hi, mid, rhs;
    lo = 0;
    hi = 128'(DistMax);
    rhs = s.num << (2 * ssd_pkg::FracBits);
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * 128'(s.den) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[ssd_pkg::DistBits-1:0];
  endfunction

  function automatic ssd_pkg::out_t seg_distance(ssd_pkg::in_t it);
    point_t a, b, c, d, r1, r2;
    sq_dist_t cand[4];
    int nc;
    bit touch;
    logic [ssd_pkg::DistBits-1:0] best, q;
    longint abx, aby, acx, acy, cdx, cdy, c1, c2, tn;
    bit tin, uin;
    ssd_pkg::out_t r;
    a = '{longint'(it.a_x), longint'(it.a_y)};
    b = '{longint'(it.b_x), longint'(it.b_y)};
    c = '{longint'(it.c_x), longint'(it.c_y)};
    d = '{longint'(it.d_x), longint'(it.d_y)};
    nc = 0;
    touch = 0;
    best = DistMax;
    if (same_pt(a, b)) begin
      cand[0] = pt_seg_sq(a, c, d);
      nc = 1;
    end else if (same_pt(c, d)) begin
      cand[0] = pt_seg_sq(c, a, b);
      nc = 1;
    end else begin
      abx = b.x - a.x; aby = b.y - a.y;
      acx = c.x - a.x; acy = c.y - a.y;
      cdx = d.x - c.x; cdy = d.y - c.y;
      c1 = abx * cdy - aby * cdx;
      c2 = acx * aby - acy * abx;
      if (c1 == 0 && c2 == 0) begin
        r1 = lex_lt(b, a) ? b : a;
        r2 = lex_lt(d, c) ? d : c;
        if (lex_lt(r1, r2)) r1 = r2;
        r2 = lex_lt(a, b) ? b : a;
        if (lex_lt(c, d)) begin
          if (lex_lt(d, r2)) r2 = d;
        end else begin
          if (lex_lt(c, r2)) r2 = c;
        end
        if (!lex_lt(r2, r1)) touch = 1;
      end else if (c1 != 0) begin
        tn = acx * cdy - acy * cdx;
        if (c1 > 0) begin
          tin = tn >= 0 && tn <= c1;
          uin = c2 >= 0 && c2 <= c1;
        end else begin
          tin = tn <= 0 && tn >= c1;
          uin = c2 <= 0 && c2 >= c1;
        end
        if (tin && uin) touch = 1;
      end
      if (!touch) begin
        cand[0] = pt_seg_sq(a, c, d);
        cand[1] = pt_seg_sq(b, c, d);
        cand[2] = pt_seg_sq(c, a, b);
        cand[3] = pt_seg_sq(d, a, b);
        nc = 4;
      end
    end
    for (int i = 0; i < nc; i++) begin
      if (cand[i].num == 0) touch = 1;
      q = fixed_root(cand[i]);
      if (q < best) best = q;
    end
    if (touch) best = '0;
    r.distance = best;
    r.touching = touch;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic ssd_pkg::in_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                                      int dx, int dy);
    ssd_pkg::in_t it;
    it.a_x = ssd_pkg::coord_t'(ax); it.a_y = ssd_pkg::coord_t'(ay);
    it.b_x = ssd_pkg::coord_t'(bx); it.b_y = ssd_pkg::coord_t'(by);
    it.c_x = ssd_pkg::coord_t'(cx); it.c_y = ssd_pkg::coord_t'(cy);
    it.d_x = ssd_pkg::coord_t'(dx); it.d_y = ssd_pkg::coord_t'(dy);
    return it;
  endfunction

  function automatic int pick_coord(int mode);
    int e;
    case (mode)
      1: return $urandom_range(16) - 8;
      2: begin
        e = $urandom_range(3);
        return e == 0 ? -32768 : e == 1 ? 32767 : e == 2 ? 0 : -1;
      end
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic ssd_pkg::in_t random_item();
    int mode, bx, by, sx, sy, k[4];
    ssd_pkg::in_t it;
    mode = $urandom_range(9);
    if (mode <= 2) begin
      it = ssd_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (mode <= 5) begin
      it = mk(pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1),
              pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1));
    end else if (mode == 6) begin
      it = mk(pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2),
              pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2));
    end else if (mode == 7) begin
      // collinear pair along a random small direction
      bx = $urandom_range(200) - 100; by = $urandom_range(200) - 100;
      sx = $urandom_range(6) - 3; sy = $urandom_range(6) - 3;
      foreach (k[i]) k[i] = $urandom_range(20) - 10;
      it = mk(bx + k[0] * sx, by + k[0] * sy, bx + k[1] * sx, by + k[1] * sy,
              bx + k[2] * sx, by + k[2] * sy, bx + k[3] * sx, by + k[3] * sy);
    end else begin
      it = mk(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0),
              pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0));
      if ($urandom_range(1)) begin
        it.b_x = it.a_x; it.b_y = it.a_y;
      end else begin
        it.d_x = it.c_x; it.d_y = it.c_y;
      end
    end
    return it;
  endfunction

  task automatic send_item(ssd_pkg::in_t it, bit known, ssd_pkg::out_t res);
    int gap, r;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(known ? res : seg_distance(it));
    items_sent++;
    r = $urandom_range(99);
    gap = r < 70 ? 0 : r < 95 ? $urandom_range(3, 1) : $urandom_range(40, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("segment_segment_distance_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    ssd_pkg::out_t want;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (result_o.touching) touches_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (result_o.distance !== want.distance)
          report_mismatch("distance", result_o.distance, want.distance);
        if (result_o.touching !== want.touching)
          report_mismatch("touching", result_o.touching, want.touching);
      end
    end
  end

  initial begin
    row_t rows[$];
    ssd_pkg::out_t z, d5, d2;
    z.distance = '0;   z.touching = 1'b1;
    d5.distance = 25'd1280; d5.touching = 1'b0;
    d2.distance = 25'd512;  d2.touching = 1'b0;
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk(0, 0, 0, 0, 3, 4, 3, 4), 1, d5});
    rows.push_back('{mk(-5, -5, 5, 5, -5, 5, 5, -5), 1, z});
    rows.push_back('{mk(0, 0, 4, 0, 2, 0, 6, 0), 1, z});
    rows.push_back('{mk(0, 0, 4, 0, 4, 0, 9, 0), 1, z});
    rows.push_back('{mk(0, 0, 1, 0, 3, 0, 5, 0), 1, d2});
    rows.push_back('{mk(0, 0, 0, 4, 0, 7, 0, 9), 0, z});
    rows.push_back('{mk(0, 0, 10, 0, 0, 3, 10, 3), 0, z});
    rows.push_back('{mk(0, 0, 10, 0, 5, 0, 5, 7), 1, z});
    rows.push_back('{mk(0, 0, 10, 0, 5, 1, 5, 7), 0, z});
    rows.push_back('{mk(2, 3, 2, 3, 0, 0, 7, 5), 0, z});
    rows.push_back('{mk(0, 0, 7, 5, 2, 3, 2, 3), 0, z});
    rows.push_back('{mk(14, 10, 14, 10, 0, 0, 7, 5), 0, z});
    rows.push_back('{mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767), 0, z});
    rows.push_back('{mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767), 0, z});
    rows.push_back('{mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1, z});
    rows.push_back('{mk(-32768, 0, -32767, 0, 32767, 1, 32767, 2), 0, z});
    rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1), 1, z});
    rows.push_back('{mk(1, 1, 3, 3, 2, 2, 5, 5), 1, z});
    rows.push_back('{mk(1, 2, 1, 5, 1, 6, 1, 9), 0, z});
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);
    repeat (RandomItems) send_item(random_item(), 0, z);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    $display("sent %0d segment pairs, checked %0d results (%0d touching)",
             items_sent, results_seen, touches_seen);
    $display("covered points, crossings, collinear overlaps, parallels and extremes");
    if (mismatches == 0) begin
      $display("segment_segment_distance_unit verification clean");
    end else begin
      $display("segment_segment_distance_unit verification failed");
    end
    $finish;
  end

endmodule
